[rtl/bts_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the bilinear texture sampler.
// No dependencies; every other file of the block except bts_ram imports this package.
package bts_pkg;

	localparam int SIZE_W      = 9;
	localparam int CFG_INDEX_W = 2;
	localparam int ADDR_MAX_W  = 24;
	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 4;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

	// Order in which the four corners are read.
	localparam logic [1:0] CORNER_00 = 2'd0;
	localparam logic [1:0] CORNER_10 = 2'd1;
	localparam logic [1:0] CORNER_01 = 2'd2;
	localparam logic [1:0] CORNER_11 = 2'd3;

	localparam logic signed [34:0] HALF_Q16 = 35'sd32768;

	typedef struct packed {
		logic               kind;
		logic [7:0]         texel_x;
		logic [7:0]         texel_y;
		logic [15:0]        write_red;
		logic [15:0]        write_green;
		logic [15:0]        write_blue;
		logic signed [23:0] u_coord;
		logic signed [23:0] v_coord;
	} bts_item_t;

	typedef struct packed {
		logic [15:0] sample_red;
		logic [15:0] sample_green;
		logic [15:0] sample_blue;
	} bts_result_t;

	// Classified request handed from front to back. A write uses addr[0].
	typedef struct packed {
		logic                             kind;
		logic [3:0][ADDR_MAX_W-1:0]       addr;
		logic [2:0][15:0]                 color;
		logic [15:0]                      fx;
		logic [15:0]                      fy;
	} bts_job_t;

	typedef struct packed {
		logic [2:0] out_count;
		logic [2:0] credits;
	} bts_status_t;

endpackage

[rtl/bts_ram.sv]
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module bts_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[rtl/bts_front.sv]
`timescale 1ns / 1ps
// Front end: size registers, request intake, coordinate mapping and corner addresses.
// Depends on bts_pkg.
module bts_front import bts_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  bts_item_t              item,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]      cfg_data,
	output logic                   job_valid,
	output bts_job_t               job,
	input  logic                   job_full
);

	localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

	logic [SIZE_W-1:0] width_q, height_q;
	logic [SIZE_W-1:0] w_use, h_use;
	logic              v_s1, v_s2;
	bts_item_t         item_s1;
	logic [SIZE_W-1:0] w_s1, h_s1;
	logic signed [34:0] prod_u_s1, prod_v_s1;
	logic              keep_s1;
	bts_job_t          job_s2, job_d;
	logic              stall, adv1, accept;
	logic signed [34:0] tu, tv;
	logic [19:0]       x0, x1, y0, y1;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s, input int mx);
		if (s == '0) begin
			return SIZE_W'(1);
		end else if (32'(s) > mx) begin
			return SIZE_W'(mx);
		end
		return s;
	endfunction

	function automatic logic [19:0] clamp_corner(input logic signed [19:0] c,
		input logic [SIZE_W-1:0] size);
		logic signed [19:0] top;
		top = signed'(20'(size)) - 20'sd1;
		if (c < 0) begin
			return '0;
		end else if (c > top) begin
			return top;
		end
		return c;
	endfunction

	function automatic logic [ADDR_MAX_W-1:0] texel_addr(input logic [19:0] x, input logic [19:0] y);
		logic [AW-1:0] a;
		a = AW'(AW'(y) * AW'(MAX_WIDTH) + AW'(x));
		return ADDR_MAX_W'(a);
	endfunction

	assign w_use = clamp_size(width_q, MAX_WIDTH);
	assign h_use = clamp_size(height_q, MAX_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign stall  = v_s2 && job_full;
	assign adv1   = !v_s1 || !stall;
	assign full   = v_s1 && stall;
	assign accept = push && !full;

	// Writes outside the store are dropped here.
	assign keep_s1 = (item_s1.kind == KIND_SAMPLE) ||
		((32'(item_s1.texel_x) < MAX_WIDTH) && (32'(item_s1.texel_y) < MAX_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= accept;
			end
			if (!stall) begin
				v_s2 <= v_s1 && keep_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && accept) begin
			item_s1   <= item;
			w_s1      <= w_use;
			h_s1      <= h_use;
			prod_u_s1 <= item.u_coord * signed'({1'b0, w_use});
			prod_v_s1 <= item.v_coord * signed'({1'b0, h_use});
		end
		if (!stall) begin
			job_s2 <= job_d;
		end
	end

	assign tu = prod_u_s1 - HALF_Q16;
	assign tv = prod_v_s1 - HALF_Q16;
	assign x0 = clamp_corner(20'(signed'(tu[34:16])), w_s1);
	assign x1 = clamp_corner(20'(signed'(tu[34:16])) + 20'sd1, w_s1);
	assign y0 = clamp_corner(20'(signed'(tv[34:16])), h_s1);
	assign y1 = clamp_corner(20'(signed'(tv[34:16])) + 20'sd1, h_s1);

	always_comb begin
		job_d       = '0;
		job_d.kind  = item_s1.kind;
		job_d.color = {item_s1.write_blue, item_s1.write_green, item_s1.write_red};
		job_d.fx    = tu[15:0];
		job_d.fy    = tv[15:0];
		if (item_s1.kind == KIND_SAMPLE) begin
			job_d.addr[CORNER_00] = texel_addr(x0, y0);
			job_d.addr[CORNER_10] = texel_addr(x1, y0);
			job_d.addr[CORNER_01] = texel_addr(x0, y1);
			job_d.addr[CORNER_11] = texel_addr(x1, y1);
		end else begin
			job_d.addr[CORNER_00] = texel_addr(20'(item_s1.texel_x), 20'(item_s1.texel_y));
		end
	end

	assign job_valid = v_s2;
	assign job       = job_s2;

endmodule

[rtl/bts_queue.sv]
`timescale 1ns / 1ps
// Short request queue that decouples front end and back end.
// Depends on bts_pkg.
module bts_queue import bts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  bts_job_t wdata,
	output logic     full,
	input  logic     pop,
	output logic     empty,
	output bts_job_t head
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	bts_job_t       mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wp_q, rp_q;
	logic [PW:0]    cnt_q;
	logic           do_push, do_pop;

	assign full    = cnt_q == (PW+1)'(QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + PW'(1);
			end
			if (do_pop) begin
				rp_q <= rp_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

endmodule

[rtl/bts_back.sv]
`timescale 1ns / 1ps
// Back end: texel store, four-read corner sequencer, blend datapath and result queue.
// Depends on bts_pkg and bts_ram.
module bts_back import bts_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int COLOR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_empty,
	input  bts_job_t    job,
	output logic        job_pop,
	input  logic        pop,
	output logic        empty,
	output bts_result_t result,
	output bts_status_t status
);

	localparam int CB = COLOR_BITS;
	localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int HW = CB + 16;
	localparam int SW = HW + 18;
	localparam int OPW = $clog2(OUT_DEPTH);
	localparam logic [SW-1:0] ROUND = SW'(64'h8000_0000);

	logic [1:0]      cnt_q;
	logic [2:0]      credits_q;
	logic            is_sample, can_issue, start, ram_we;
	logic [AW-1:0]   ram_addr;
	logic [3*CB-1:0] ram_wdata, ram_rdata;
	logic            tag_v_s1;
	logic [1:0]      tag_corner_s1;
	logic [15:0]     tag_fx_s1, tag_fy_s1;
	logic [2:0][CB-1:0] c0_q, c2_q;
	logic [2:0][HW-1:0] h0_q, h0_s2, h1_s2;
	logic [15:0]     fy_s2;
	logic            v_s2;
	logic [2:0][15:0] fin;
	bts_result_t     out_q [OUT_DEPTH];
	logic [OPW-1:0]  owp_q, orp_q;
	logic [OPW:0]    ocnt_q;
	logic            do_pop;

	function automatic logic [HW-1:0] lerp(input logic [CB-1:0] a, input logic [CB-1:0] b,
		input logic [15:0] f);
		logic signed [CB:0]    d;
		logic signed [CB+17:0] p;
		d = signed'({1'b0, b}) - signed'({1'b0, a});
		p = d * signed'({1'b0, f});
		p = p + signed'({2'b00, a, 16'h0000});
		return p[HW-1:0];
	endfunction

	function automatic logic [15:0] finish(input logic [HW-1:0] a, input logic [HW-1:0] b,
		input logic [15:0] f);
		logic signed [HW:0]   d;
		logic signed [SW-1:0] s;
		logic [CB-1:0]        r;
		d = signed'({1'b0, b}) - signed'({1'b0, a});
		s = d * signed'({1'b0, f});
		s = s + signed'({2'b00, a, 16'h0000}) + signed'(ROUND);
		r = s[CB+31:32];
		return 16'(r);
	endfunction

	// Issue: a write is a single store write, a sample four reads in a row.
	assign is_sample = job.kind == KIND_SAMPLE;
	assign start     = !job_empty && is_sample && (cnt_q == CORNER_00) &&
		(credits_q < 3'(OUT_DEPTH));
	assign can_issue = !job_empty && is_sample && ((cnt_q != CORNER_00) || start);
	assign ram_we    = !job_empty && !is_sample;
	assign job_pop   = ram_we || (can_issue && (cnt_q == CORNER_11));
	assign ram_addr  = AW'(job.addr[cnt_q]);
	assign ram_wdata = {CB'(job.color[2]), CB'(job.color[1]), CB'(job.color[0])};

	bts_ram #(.WIDTH(3 * CB), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= CORNER_00;
			credits_q <= '0;
			tag_v_s1  <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			if (can_issue) begin
				cnt_q <= cnt_q + 2'd1;
			end
			credits_q <= credits_q + 3'(start) - 3'(do_pop);
			tag_v_s1  <= can_issue;
			v_s2      <= tag_v_s1 && (tag_corner_s1 == CORNER_11);
		end
	end

	always_ff @(posedge clk) begin
		tag_corner_s1 <= cnt_q;
		tag_fx_s1     <= job.fx;
		tag_fy_s1     <= job.fy;
		if (tag_v_s1) begin
			for (int i = 0; i < 3; i++) begin
				case (tag_corner_s1)
					CORNER_00: c0_q[i] <= ram_rdata[i*CB +: CB];
					CORNER_10: h0_q[i] <= lerp(c0_q[i], ram_rdata[i*CB +: CB], tag_fx_s1);
					CORNER_01: c2_q[i] <= ram_rdata[i*CB +: CB];
					CORNER_11: begin
						h1_s2[i] <= lerp(c2_q[i], ram_rdata[i*CB +: CB], tag_fx_s1);
						h0_s2[i] <= h0_q[i];
					end
					default: ;
				endcase
			end
			fy_s2 <= tag_fy_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fin[i] = finish(h0_s2[i], h1_s2[i], fy_s2);
		end
	end

	// Result queue; credits keep it from overflowing.
	always_ff @(posedge clk) begin
		if (v_s2) begin
			out_q[owp_q] <= '{sample_red: fin[0], sample_green: fin[1], sample_blue: fin[2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (v_s2) begin
				owp_q <= owp_q + OPW'(1);
			end
			if (do_pop) begin
				orp_q <= orp_q + OPW'(1);
			end
			ocnt_q <= ocnt_q + (OPW+1)'(v_s2) - (OPW+1)'(do_pop);
		end
	end

	assign empty  = ocnt_q == '0;
	assign result = out_q[orp_q];
	assign status = '{out_count: 3'(ocnt_q), credits: credits_q};

endmodule

[rtl/bilinear_texture_sampler.sv]
`timescale 1ns / 1ps
// Top level of the bilinear texture sampler with clamp-to-edge addressing.
// Depends on bts_pkg, bts_front, bts_queue, bts_back and bts_ram.
//
// Channel   Handshake             Payload        Notes
// item      push / full           bts_item_t     write texel or sample request
// result    empty / pop           bts_result_t   one per sample, none per write
// config    cfg_we (no wait)      cfg_data       cfg_index 0 width, 1 height
//
// A sample occupies the back end for four corner reads in a row of the
// single-port texel store; a write occupies it for a single store write.
// Reset clears control state only; the texel store holds garbage until written.
// The front end and back end stall independently through a four-entry request queue;
// a four-entry result queue absorbs pop stalls.
module bilinear_texture_sampler import bts_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int COLOR_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  bts_item_t              item,
	input  logic                   pop,
	output logic                   empty,
	output bts_result_t            result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]      cfg_data
);

	logic        job_valid, q_full, q_empty, q_pop;
	bts_job_t    job_in, job_head;
	bts_status_t status;

	// Accept, map coordinates and form corner addresses.
	bts_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job_valid (job_valid),
		.job       (job_in),
		.job_full  (q_full)
	);

	// Hold classified requests until the back end is free.
	bts_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_valid),
		.wdata  (job_in),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.head   (job_head)
	);

	// Read corners, blend and deliver results.
	bts_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .COLOR_BITS(COLOR_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (q_empty),
		.job       (job_head),
		.job_pop   (q_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result),
		.status    (status)
	);

	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && q_full |=> job_valid && $stable(job_in))
		else $error("front dropped or changed a request waiting on a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("back end took a request from an empty queue");

	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(status.out_count <= status.credits) && (status.credits <= 3'(OUT_DEPTH)))
		else $error("result queue exceeds its credits");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bilinear_texture_sampler: texel writes and
// bilinear samples under several image sizes, checked against a local predictor.
// Depends on bts_pkg and the bilinear_texture_sampler RTL.
module testbench;
	import bts_pkg::*;

	localparam int STORE_W   = 256;
	localparam int STORE_H   = 256;
	localparam int WATCHDOG  = 20000;
	localparam int DRAIN_CYC = 40;
	localparam int ITEM_W    = $bits(bts_item_t);

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   push = 1'b0;
	logic                   full;
	bts_item_t              item = '0;
	logic                   pop = 1'b0;
	logic                   empty;
	bts_result_t            result;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
	logic [SIZE_W-1:0]      cfg_data = '0;

	bilinear_texture_sampler DUT (.*);

	always #5 clk = ~clk;

	// Predictor state: configured sizes and the texel store as the block sees it.
	logic [SIZE_W-1:0] pred_width = SIZE_RESET;
	logic [SIZE_W-1:0] pred_height = SIZE_RESET;
	logic [47:0]       pred_texels [STORE_W*STORE_H];
	// Texels that the stimulus has already scheduled a write for.
	bit                scheduled [STORE_W*STORE_H];

	bts_item_t   pending_requests [$];
	bts_result_t expected_colors [$];
	int          errors = 0;
	int          cycle = 0;
	int          idle_cycles = 0;
	bit          accepted_any;
	bit          run_done = 1'b0;

	// Saturate a size register to the range the store supports.
	function automatic int used_size(logic [SIZE_W-1:0] s, int limit);
		if (s == 0) return 1;
		if (s > limit) return limit;
		return s;
	endfunction

	// t = coord*size - 0.5 in Q.16; floor gives the lower corner, remainder the weight.
	function automatic void axis_corners(logic signed [23:0] coord, int size,
			output int c0, output int c1, output longint unsigned f);
		longint t;
		longint fl;
		t  = longint'(coord) * size - 32768;
		f  = t & 64'hFFFF;
		fl = t >>> 16;
		c0 = (fl < 0) ? 0 : (fl > size - 1) ? size - 1 : int'(fl);
		c1 = (fl + 1 < 0) ? 0 : (fl + 1 > size - 1) ? size - 1 : int'(fl + 1);
	endfunction

	function automatic logic [15:0] blend_channel(longint unsigned p00, p10, p01, p11,
			longint unsigned fx, fy);
		longint unsigned h0, h1, sum;
		h0  = p00 * (65536 - fx) + p10 * fx;
		h1  = p01 * (65536 - fx) + p11 * fx;
		sum = h0 * (65536 - fy) + h1 * fy;
		return 16'((sum + 64'h8000_0000) >> 32);
	endfunction

	// Apply one accepted request to the predictor and queue its result if any.
	function automatic void predict_request(bts_item_t req);
		int x0, x1, y0, y1;
		longint unsigned fx, fy;
		logic [47:0] t00, t10, t01, t11;
		bts_result_t r;
		if (req.kind == KIND_WRITE) begin
			pred_texels[req.texel_y * STORE_W + req.texel_x] =
				{req.write_red, req.write_green, req.write_blue};
			return;
		end
		axis_corners(req.u_coord, used_size(pred_width, STORE_W), x0, x1, fx);
		axis_corners(req.v_coord, used_size(pred_height, STORE_H), y0, y1, fy);
		t00 = pred_texels[y0 * STORE_W + x0];
		t10 = pred_texels[y0 * STORE_W + x1];
		t01 = pred_texels[y1 * STORE_W + x0];
		t11 = pred_texels[y1 * STORE_W + x1];
		r.sample_red   = blend_channel(t00[47:32], t10[47:32], t01[47:32], t11[47:32], fx, fy);
		r.sample_green = blend_channel(t00[31:16], t10[31:16], t01[31:16], t11[31:16], fx, fy);
		r.sample_blue  = blend_channel(t00[15:0], t10[15:0], t01[15:0], t11[15:0], fx, fy);
		expected_colors.push_back(r);
	endfunction

	// Idle with a probability of 7 in 100, except in a stretch mid-run with no idling.
	function automatic bit take_gap();
		if (cycle >= 800 && cycle < 1600) return 1'b0;
		return $urandom_range(99) < 7;
	endfunction

	// Driver: advance to the next request once the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) predict_request(item);
			if (!push || !full) begin
				if (pending_requests.size() > 0 && !take_gap()) begin
					push <= 1'b1;
					item <= pending_requests.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random, check each popped result against the oldest one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_colors.size() == 0) begin
					$display("%0t: result with none expected: got %h", $time, result);
					errors++;
				end else begin
					bts_result_t e;
					e = expected_colors.pop_front();
					if (result.sample_red !== e.sample_red) begin
						$display("%0t: sample_red expected %h got %h", $time,
							e.sample_red, result.sample_red);
						errors++;
					end
					if (result.sample_green !== e.sample_green) begin
						$display("%0t: sample_green expected %h got %h", $time,
							e.sample_green, result.sample_green);
						errors++;
					end
					if (result.sample_blue !== e.sample_blue) begin
						$display("%0t: sample_blue expected %h got %h", $time,
							e.sample_blue, result.sample_blue);
						errors++;
					end
				end
			end
			pop <= !take_gap();
		end
	end

	// Watchdog: count cycles in which no request, result or register write moves.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		accepted_any = (push && !full) || (pop && !empty) || cfg_we;
		if (accepted_any || run_done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("timeout after %0d idle cycles, %0d results outstanding",
				idle_cycles, expected_colors.size());
			$display("[bilinear_texture_sampler] ERROR");
			$finish;
		end
	end

	// Queue a texel write and remember that the location will hold data.
	task automatic add_write(int x, int y);
		bts_item_t req;
		req = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
		req.kind    = KIND_WRITE;
		req.texel_x = 8'(x);
		req.texel_y = 8'(y);
		scheduled[y * STORE_W + x] = 1'b1;
		pending_requests.push_back(req);
	endtask

	// Queue a sample; write any corner it would read that holds no data yet.
	task automatic add_sample(logic signed [23:0] u, logic signed [23:0] v);
		int x0, x1, y0, y1;
		longint unsigned fx, fy;
		bts_item_t req;
		axis_corners(u, used_size(pred_width, STORE_W), x0, x1, fx);
		axis_corners(v, used_size(pred_height, STORE_H), y0, y1, fy);
		if (!scheduled[y0 * STORE_W + x0]) add_write(x0, y0);
		if (!scheduled[y0 * STORE_W + x1]) add_write(x1, y0);
		if (!scheduled[y1 * STORE_W + x0]) add_write(x0, y1);
		if (!scheduled[y1 * STORE_W + x1]) add_write(x1, y1);
		req = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
		req.kind    = KIND_SAMPLE;
		req.u_coord = u;
		req.v_coord = v;
		pending_requests.push_back(req);
	endtask

	// Mostly coordinates in and near [0,1), some anywhere in the Q8.16 range.
	function automatic logic signed [23:0] rand_coord();
		case ($urandom_range(9))
			0:       return 24'($urandom);
			1:       return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
			2:       return 24'sd65536 + 24'($urandom_range(4096)) - 24'sd2048;
			3:       return 24'($urandom_range(4096)) - 24'sd2048;
			default: return 24'($urandom_range(65535));
		endcase
	endfunction

	// Hold the sender until every queued request is taken and every result is in.
	task automatic drain();
		wait (pending_requests.size() == 0 && !push);
		wait (expected_colors.size() == 0);
		// let a trailing write retire before touching the registers
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_size(logic [CFG_INDEX_W-1:0] index, logic [SIZE_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == CFG_IMAGE_WIDTH) pred_width = value;
		else pred_height = value;
	endtask

	task automatic random_phase(int count);
		repeat (count) begin
			if ($urandom_range(3) == 0)
				add_write($urandom_range(255), $urandom_range(255));
			else
				add_sample(rand_coord(), rand_coord());
		end
	endtask

	logic [SIZE_W-1:0] widths [8]  = '{9'd1, 9'd0, 9'd3, 9'd511, 9'd2, 9'd256, 9'd17, 9'd8};
	logic [SIZE_W-1:0] heights [8] = '{9'd1, 9'd0, 9'd5, 9'd300, 9'd7, 9'd256, 9'd4, 9'd2};

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: corner texels, extreme colors, extreme and edge coordinates
		// at the reset size of 256 by 256.
		add_write(0, 0);
		pending_requests[$].write_red   = 16'h0000;
		pending_requests[$].write_green = 16'hFFFF;
		pending_requests[$].write_blue  = 16'h0000;
		add_write(255, 255);
		pending_requests[$].write_red   = 16'hFFFF;
		pending_requests[$].write_green = 16'h0000;
		pending_requests[$].write_blue  = 16'hFFFF;
		add_write(255, 0);
		add_write(0, 255);
		add_sample(24'sh000000, 24'sh000000);
		add_sample(24'sh800000, 24'sh800000);
		add_sample(24'sh7FFFFF, 24'sh7FFFFF);
		add_sample(24'sh7FFFFF, 24'sh800000);
		add_sample(24'sh00FFFF, 24'sh000000);
		add_sample(24'sh000080, 24'sh000080);
		add_sample(24'sh0000C0, 24'sh008000);
		add_sample(24'sh010000, 24'sh00FFFF);
		// overwrite a texel that is in use and sample it again
		add_write(0, 0);
		add_sample(24'sh000000, 24'sh000000);
		drain();

		random_phase(40);
		drain();

		// Walk the size settings, saturating ones included; the store is never cleared.
		foreach (widths[i]) begin
			write_size(CFG_IMAGE_WIDTH, widths[i]);
			write_size(CFG_IMAGE_HEIGHT, heights[i]);
			random_phase(45);
			drain();
		end

		run_done = 1'b1;
		if (errors == 0 && expected_colors.size() == 0) begin
			$display("[bilinear_texture_sampler] OK");
		end else begin
			$display("%0d results never arrived", expected_colors.size());
			$display("[bilinear_texture_sampler] ERROR");
		end
		$finish;
	end
endmodule
